/* rtl/rffa_pkg.sv */
// Shared types and constants for the rotating first-fit slot allocator.
// No dependencies; every other file in this folder imports it.
package rffa_pkg;

  // Default and upper bound for the host count
  localparam int MAX_HOSTS_DEF = 8;
  localparam int SLOT_PORTS    = 8;

  // Field widths
  localparam int MSG_W   = 8;
  localparam int SLOT_W  = 8;
  localparam int NUMH_W  = 4;
  localparam int HOST_W  = 3;
  localparam int STAT_W  = 2;
  localparam int ROT_W   = 32;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOTS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request, advance rotation
    logic step;        // place messages on the current host
    logic emit_one;    // load the single empty / failure result
    logic emit_entry;  // load the next placement result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic special;     // empty request or no hosts
    logic walk_done;   // all hosts walked or nothing left to place
    logic short_fall;  // messages remain after the walk
    logic last_entry;  // next placement result is the final one
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

/* rtl/rffa_ctrl.sv */
// Controller state machine for the slot allocator.
// Depends on rffa_pkg for command and status types.
module rffa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rffa_pkg::sts_t sts,
  output rffa_pkg::cmd_t cmd
);
  import rffa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_WALK     = 4'b0010,
    S_EMIT_ONE = 4'b0100,
    S_EMIT     = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.special) begin
          state_next = S_EMIT_ONE;
        end else if (sts.walk_done) begin
          state_next = sts.short_fall ? S_EMIT_ONE : S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT_ONE: begin
        if (sts.out_free) begin
          cmd.emit_one = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          if (sts.last_entry) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rffa_dpath.sv */
// Datapath for the slot allocator: rotation counter, host walk, result
// buffer and output register. Depends on rffa_pkg.
module rffa_dpath #(
  parameter int MAX_HOSTS = rffa_pkg::MAX_HOSTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rffa_pkg::cmd_t              cmd,
  output rffa_pkg::sts_t              sts,
  input  logic [rffa_pkg::MSG_W-1:0]  num_msgs,
  input  logic                        single_host,
  input  logic [rffa_pkg::NUMH_W-1:0] num_hosts,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots [rffa_pkg::SLOT_PORTS],
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rffa_pkg::HOST_W-1:0] host_index,
  output logic [rffa_pkg::MSG_W-1:0]  msg_count,
  output logic [rffa_pkg::MSG_W-1:0]  first_msg,
  output logic [rffa_pkg::STAT_W-1:0] status,
  output logic                        last
);
  import rffa_pkg::*;

  localparam int IDX_W = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int CNT_W = $clog2(MAX_HOSTS + 1);

  // Rotation counter and its residue modulo each host count (i+1)
  logic [ROT_W-1:0]  rot_count;
  logic [HOST_W-1:0] res      [MAX_HOSTS];
  logic [HOST_W-1:0] res_next [MAX_HOSTS];
  logic [ROT_W-1:0]  cnt_inc;
  logic [NUMH_W-1:0] hosts_in;
  logic [HOST_W-1:0] start;

  // Captured request and walk state
  logic [SLOT_W-1:0] slots [SLOT_PORTS];
  logic [NUMH_W-1:0] hosts_c;
  logic [NUMH_W-1:0] walk_len;
  logic              is_empty;
  logic              no_hosts;
  logic [HOST_W-1:0] host_ptr;
  logic [NUMH_W-1:0] step_cnt;
  logic [MSG_W-1:0]  left;
  logic [MSG_W-1:0]  next_msg;

  // Placement results, in walk order
  logic [HOST_W-1:0] ent_host  [MAX_HOSTS];
  logic [MSG_W-1:0]  ent_cnt   [MAX_HOSTS];
  logic [MSG_W-1:0]  ent_first [MAX_HOSTS];
  logic [CNT_W-1:0]  ent_n;
  logic [CNT_W-1:0]  ent_k;

  logic [SLOT_W-1:0] cur_slots;
  logic [MSG_W-1:0]  take;
  logic [NUMH_W-1:0] ptr_inc;
  logic [HOST_W-1:0] ptr_next;

  // Clamp host count, step residues, pick start host
  always_comb begin
    hosts_in = (num_hosts > NUMH_W'(MAX_HOSTS)) ? NUMH_W'(MAX_HOSTS) : num_hosts;
    cnt_inc  = rot_count + ROT_W'(1);
    start    = '0;
    for (int i = 0; i < MAX_HOSTS; i++) begin
      if (cnt_inc == '0 || res[i] == HOST_W'(i)) begin
        res_next[i] = '0;
      end else begin
        res_next[i] = res[i] + HOST_W'(1);
      end
      if (hosts_in == NUMH_W'(i + 1)) begin
        start = res_next[i];
      end
    end
  end

  // Messages for the current host and the wrapping pointer
  always_comb begin
    cur_slots = slots[host_ptr];
    take      = (cur_slots < left) ? cur_slots : left;
    ptr_inc   = {1'b0, host_ptr} + NUMH_W'(1);
    ptr_next  = (ptr_inc == hosts_c) ? '0 : ptr_inc[HOST_W-1:0];
  end

  // Report walk progress to the controller
  always_comb begin
    sts.special    = is_empty || no_hosts;
    sts.walk_done  = (step_cnt == walk_len) || (left == '0);
    sts.short_fall = (left != '0);
    sts.last_entry = ((ent_k + CNT_W'(1)) == ent_n);
    sts.out_free   = !out_valid || !out_stall;
  end

  // Rotation state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_count <= '0;
      for (int i = 0; i < MAX_HOSTS; i++) begin
        res[i] <= '0;
      end
      step_cnt  <= '0;
      ent_n     <= '0;
      ent_k     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (hosts_in != '0) begin
          rot_count <= cnt_inc;
          res       <= res_next;
        end
        step_cnt <= '0;
        ent_n    <= '0;
        ent_k    <= '0;
      end
      if (cmd.step) begin
        step_cnt <= step_cnt + NUMH_W'(1);
        if (take != '0) begin
          ent_n <= ent_n + CNT_W'(1);
        end
      end
      if (cmd.emit_entry) begin
        ent_k <= ent_k + CNT_W'(1);
      end
      if (cmd.emit_one || cmd.emit_entry) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slots    <= free_slots;
      hosts_c  <= hosts_in;
      walk_len <= single_host ? NUMH_W'(1) : hosts_in;
      is_empty <= (num_msgs == '0);
      no_hosts <= (hosts_in == '0);
      host_ptr <= start;
      left     <= num_msgs;
      next_msg <= '0;
    end
    if (cmd.step) begin
      if (take != '0) begin
        ent_host[ent_n[IDX_W-1:0]]  <= host_ptr;
        ent_cnt[ent_n[IDX_W-1:0]]   <= take;
        ent_first[ent_n[IDX_W-1:0]] <= next_msg;
      end
      left     <= left - take;
      next_msg <= next_msg + take;
      host_ptr <= ptr_next;
    end
    if (cmd.emit_one) begin
      host_index <= '0;
      msg_count  <= '0;
      first_msg  <= '0;
      status     <= is_empty ? ST_EMPTY : ST_NO_SLOTS;
      last       <= 1'b1;
    end
    if (cmd.emit_entry) begin
      host_index <= ent_host[ent_k[IDX_W-1:0]];
      msg_count  <= ent_cnt[ent_k[IDX_W-1:0]];
      first_msg  <= ent_first[ent_k[IDX_W-1:0]];
      status     <= ST_OK;
      last       <= sts.last_entry;
    end
  end

endmodule

/* rtl/rotating_first_fit_slot_allocator.sv */
// Channel   Direction  Handshake             Contents
// request   in         in_valid / in_stall   num_msgs, single_host, num_hosts, free_slots_0..7
// result    out        out_valid / out_stall host_index, msg_count, first_msg, status, last
//
// One request at a time: the controller takes it, walks the hosts and decides, then
// emits each result as the output register frees, or one empty or failure result.
// The host walk visits one host a cycle.
// Reset clears the rotation counter and the controller; no clearing pass.
// A stalled result holds in the output register; the next request is taken
// while the final result of the previous one still waits.
//
// Top level: controller and datapath. Depends on rffa_pkg, rffa_ctrl, rffa_dpath.
module rotating_first_fit_slot_allocator #(
  parameter int MAX_HOSTS = rffa_pkg::MAX_HOSTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rffa_pkg::MSG_W-1:0]  num_msgs,
  input  logic                        single_host,
  input  logic [rffa_pkg::NUMH_W-1:0] num_hosts,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_0,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_1,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_2,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_3,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_4,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_5,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_6,
  input  logic [rffa_pkg::SLOT_W-1:0] free_slots_7,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rffa_pkg::HOST_W-1:0] host_index,
  output logic [rffa_pkg::MSG_W-1:0]  msg_count,
  output logic [rffa_pkg::MSG_W-1:0]  first_msg,
  output logic [rffa_pkg::STAT_W-1:0] status,
  output logic                        last
);
  import rffa_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [SLOT_W-1:0] free_slots [SLOT_PORTS];

  // Gather per-host slot counts
  assign free_slots[0] = free_slots_0;
  assign free_slots[1] = free_slots_1;
  assign free_slots[2] = free_slots_2;
  assign free_slots[3] = free_slots_3;
  assign free_slots[4] = free_slots_4;
  assign free_slots[5] = free_slots_5;
  assign free_slots[6] = free_slots_6;
  assign free_slots[7] = free_slots_7;

  rffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rffa_dpath #(
    .MAX_HOSTS (MAX_HOSTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .num_msgs    (num_msgs),
    .single_host (single_host),
    .num_hosts   (num_hosts),
    .free_slots  (free_slots),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .host_index  (host_index),
    .msg_count   (msg_count),
    .first_msg   (first_msg),
    .status      (status),
    .last        (last)
  );

endmodule

/* rtl/rffa_checker.sv */
// Port-level checks for the slot allocator, bound to the top level.
// Depends on rffa_pkg for status codes.
module rffa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rffa_pkg::HOST_W-1:0] host_index,
  input logic [rffa_pkg::MSG_W-1:0]  msg_count,
  input logic [rffa_pkg::MSG_W-1:0]  first_msg,
  input logic [rffa_pkg::STAT_W-1:0] status,
  input logic                        last
);
  import rffa_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(host_index) && $stable(msg_count)
      && $stable(first_msg) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // Busy after a request transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // Empty and failure results stand alone and carry no placement
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && host_index == '0 && msg_count == '0
      && first_msg == '0)
    else $error("malformed empty or failure result");

  // A placement always moves at least one message
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> msg_count != '0)
    else $error("placement of zero messages");

endmodule

bind rotating_first_fit_slot_allocator rffa_checker u_rffa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .host_index (host_index),
  .msg_count  (msg_count),
  .first_msg  (first_msg),
  .status     (status),
  .last       (last)
);

/* bench/tb.sv */
// Testbench for rotating_first_fit_slot_allocator: directed and random placement requests,
// each predicted at its transfer and checked result by result against the output channel.
// Depends on rtl/rffa_pkg.sv and rtl/rotating_first_fit_slot_allocator.sv.
`timescale 1ns / 1ps

module tb;
  import rffa_pkg::*;

  // One placement request as queued for the driver
  typedef struct packed {
    logic                                hold;   // wait for every pending result first
    logic [5:0]                          gap;    // idle cycles after this transfer
    logic [MSG_W-1:0]                    msgs;
    logic                                single;
    logic [NUMH_W-1:0]                   hosts;
    logic [SLOT_PORTS-1:0][SLOT_W-1:0]   slots;
  } request_t;

  // One run of messages placed on a host
  typedef struct packed {
    logic [HOST_W-1:0] host;
    logic [MSG_W-1:0]  count;
    logic [MSG_W-1:0]  first;
    logic [STAT_W-1:0] status;
    logic              last;
  } placement_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MSG_W-1:0]  num_msgs = '0;
  logic              single_host = 1'b0;
  logic [NUMH_W-1:0] num_hosts = '0;
  logic [SLOT_W-1:0] free_slots_0 = '0;
  logic [SLOT_W-1:0] free_slots_1 = '0;
  logic [SLOT_W-1:0] free_slots_2 = '0;
  logic [SLOT_W-1:0] free_slots_3 = '0;
  logic [SLOT_W-1:0] free_slots_4 = '0;
  logic [SLOT_W-1:0] free_slots_5 = '0;
  logic [SLOT_W-1:0] free_slots_6 = '0;
  logic [SLOT_W-1:0] free_slots_7 = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [HOST_W-1:0] host_index;
  logic [MSG_W-1:0]  msg_count;
  logic [MSG_W-1:0]  first_msg;
  logic [STAT_W-1:0] status;
  logic              last;

  request_t   request_q[$];
  placement_t placement_q[$];
  request_t   next_req;
  logic [ROT_W-1:0] rotation = '0;
  logic       req_sent = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         calm_left = 0;
  int         errors = 0;

  rotating_first_fit_slot_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .num_msgs     (num_msgs),
    .single_host  (single_host),
    .num_hosts    (num_hosts),
    .free_slots_0 (free_slots_0),
    .free_slots_1 (free_slots_1),
    .free_slots_2 (free_slots_2),
    .free_slots_3 (free_slots_3),
    .free_slots_4 (free_slots_4),
    .free_slots_5 (free_slots_5),
    .free_slots_6 (free_slots_6),
    .free_slots_7 (free_slots_7),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .host_index   (host_index),
    .msg_count    (msg_count),
    .first_msg    (first_msg),
    .status       (status),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the rotation and queue the runs that one request places
  task automatic place_request(input request_t r);
    placement_t  runs[$];
    placement_t  run;
    int unsigned n_hosts, start, walk, left, next_msg, h, take, i;
    n_hosts = (r.hosts > MAX_HOSTS_DEF) ? MAX_HOSTS_DEF : r.hosts;
    start = 0;
    if (n_hosts != 0) begin
      rotation = rotation + 1'b1;
      start = rotation % n_hosts;
    end
    run = '0;
    run.last = 1'b1;
    if (r.msgs == 0) begin
      run.status = ST_EMPTY;
      placement_q.insert(placement_q.size(), run);
    end else if (n_hosts == 0) begin
      run.status = ST_NO_SLOTS;
      placement_q.insert(placement_q.size(), run);
    end else begin
      walk = r.single ? 1 : n_hosts;
      left = r.msgs;
      next_msg = 0;
      for (i = 0; i < walk && left != 0; i++) begin
        h = start + i;
        if (h >= n_hosts) h -= n_hosts;
        take = (r.slots[h] < left) ? r.slots[h] : left;
        // skip hosts with no free slots
        if (take != 0) begin
          runs.insert(runs.size(), '{host: HOST_W'(h), count: MSG_W'(take),
                                     first: MSG_W'(next_msg), status: ST_OK, last: 1'b0});
          next_msg += take;
          left -= take;
        end
      end
      if (left != 0) begin
        // shortfall: report the failure alone, never a partial placement
        run.status = ST_NO_SLOTS;
        placement_q.insert(placement_q.size(), run);
      end else begin
        runs[runs.size()-1].last = 1'b1;
        foreach (runs[k]) placement_q.insert(placement_q.size(), runs[k]);
      end
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Predict on each request transfer; check each result transfer
  always @(posedge clk) begin
    req_sent <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        place_request('{hold: 1'b0, gap: '0, msgs: num_msgs, single: single_host,
                        hosts: num_hosts,
                        slots: {free_slots_7, free_slots_6, free_slots_5, free_slots_4,
                                free_slots_3, free_slots_2, free_slots_1, free_slots_0}});
      if (out_valid && !out_stall) begin
        if (placement_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual host %0d count %0d",
                   $time, host_index, msg_count,
                   " first %0d status %0d last %0d", first_msg, status, last);
          errors++;
        end else begin
          report_field("host_index", 32'(placement_q[0].host), 32'(host_index));
          report_field("msg_count", 32'(placement_q[0].count), 32'(msg_count));
          report_field("first_msg", 32'(placement_q[0].first), 32'(first_msg));
          report_field("status", 32'(placement_q[0].status), 32'(status));
          report_field("last", 32'(placement_q[0].last), 32'(last));
          void'(placement_q.pop_front());
        end
      end
    end
  end

  // Drive requests and the result stall at the falling edge
  always @(negedge clk) begin
    if (!rst && (!in_valid || req_sent)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() != 0 &&
                   (!request_q[0].hold || placement_q.size() == 0)) begin
        next_req = request_q.pop_front();
        num_msgs     <= next_req.msgs;
        single_host  <= next_req.single;
        num_hosts    <= next_req.hosts;
        free_slots_0 <= next_req.slots[0];
        free_slots_1 <= next_req.slots[1];
        free_slots_2 <= next_req.slots[2];
        free_slots_3 <= next_req.slots[3];
        free_slots_4 <= next_req.slots[4];
        free_slots_5 <= next_req.slots[5];
        free_slots_6 <= next_req.slots[6];
        free_slots_7 <= next_req.slots[7];
        in_valid     <= 1'b1;
        gap_left     <= next_req.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end

    // stall bursts, mostly short, separated by calm stretches of varying length
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (calm_left != 0) begin
        calm_left <= calm_left - 1;
      end else begin
        case ($urandom_range(0, 9))
          7, 8:    stall_left <= $urandom_range(4, 10);
          9:       stall_left <= $urandom_range(15, 30);
          default: stall_left <= $urandom_range(1, 3);
        endcase
        case ($urandom_range(0, 9))
          7, 8:    calm_left <= $urandom_range(6, 20);
          9:       calm_left <= $urandom_range(60, 150);
          default: calm_left <= $urandom_range(0, 5);
        endcase
      end
    end
  end

  task automatic queue_request(input logic [MSG_W-1:0] msgs, input logic single,
                               input logic [NUMH_W-1:0] hosts,
                               input logic [SLOT_PORTS*SLOT_W-1:0] slots,
                               input logic hold, input logic [5:0] gap);
    request_q.insert(request_q.size(), '{hold: hold, gap: gap, msgs: msgs, single: single,
                                         hosts: hosts, slots: slots});
  endtask

  // Mostly placeable batches with random content, with shortfalls and noise mixed in
  function automatic request_t random_request(input int idx);
    request_t    r;
    int unsigned n, cap, low, h;
    r = '0;
    case ($urandom_range(0, 19))
      0:       r.hosts = '0;
      1:       r.hosts = NUMH_W'($urandom_range(9, 15));
      default: r.hosts = NUMH_W'($urandom_range(1, 8));
    endcase
    r.single = ($urandom_range(0, 3) == 0);
    for (h = 0; h < SLOT_PORTS; h++) begin
      case ($urandom_range(0, 9))
        0:       r.slots[h] = '0;
        1:       r.slots[h] = '1;
        2, 3:    r.slots[h] = SLOT_W'($urandom);
        default: r.slots[h] = SLOT_W'($urandom_range(1, 40));
      endcase
    end
    n = (r.hosts > MAX_HOSTS_DEF) ? MAX_HOSTS_DEF : r.hosts;
    cap = 0;
    low = 255;
    for (h = 0; h < n; h++) begin
      cap += r.slots[h];
      if (r.slots[h] < low) low = r.slots[h];
    end
    // with one host allowed, size the batch to fit whichever host starts
    if (r.single) cap = low;
    if (cap > 255) cap = 255;
    case ($urandom_range(0, 9))
      0:       r.msgs = '0;
      1:       r.msgs = MSG_W'($urandom);
      2:       r.msgs = MSG_W'((cap < 255) ? cap + 1 : 255);
      default: r.msgs = MSG_W'((cap != 0) ? $urandom_range(1, cap) : $urandom_range(1, 255));
    endcase
    if (idx >= 120 && idx < 160) begin
      r.gap = '0;
    end else begin
      case ($urandom_range(0, 19))
        10, 11, 12, 13, 14, 15, 16: r.gap = 6'($urandom_range(1, 3));
        17, 18:                     r.gap = 6'($urandom_range(4, 12));
        19:                         r.gap = 6'($urandom_range(20, 50));
        default:                    r.gap = '0;
      endcase
    end
    r.hold = (idx == 60) || (idx == 200);
    return r;
  endfunction

  initial begin
    // empty request with no hosts: empty wins, rotation holds
    queue_request(8'd0, 1'b0, 4'd0, '0, 1'b0, 6'd0);
    // no hosts at all
    queue_request(8'd5, 1'b0, 4'd0, {8{8'd9}}, 1'b0, 6'd0);
    // empty request that still advances the rotation
    queue_request(8'd0, 1'b0, 4'd3, {8{8'd4}}, 1'b0, 6'd2);
    // host count above the limit, full batch on one host
    queue_request(8'd255, 1'b0, 4'd15, {8{8'd255}}, 1'b0, 6'd0);
    // batch spread over all eight hosts
    queue_request(8'd255, 1'b0, 4'd8, {8{8'd32}}, 1'b0, 6'd0);
    // exact fit with a saturated host count
    queue_request(8'd240, 1'b0, 4'd9, {8{8'd30}}, 1'b0, 6'd0);
    // shortfall by a single message
    queue_request(8'd241, 1'b0, 4'd8, {8{8'd30}}, 1'b0, 6'd1);
    // single host, fits and then falls short
    queue_request(8'd10, 1'b1, 4'd4, {8{8'd10}}, 1'b0, 6'd0);
    queue_request(8'd11, 1'b1, 4'd4, {8{8'd10}}, 1'b0, 6'd0);
    // hosts with no free slots are skipped
    queue_request(8'd20, 1'b0, 4'd6,
                  {8'd0, 8'd0, 8'd13, 8'd0, 8'd0, 8'd7, 8'd0, 8'd0}, 1'b0, 6'd0);
    queue_request(8'd1, 1'b0, 4'd1, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255},
                  1'b0, 6'd0);
    queue_request(8'd255, 1'b0, 4'd1, {8{8'd255}}, 1'b0, 6'd0);
    // every host full
    queue_request(8'd255, 1'b0, 4'd8, '0, 1'b0, 6'd3);
    queue_request(8'd1, 1'b0, 4'd8, {8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
                  1'b0, 6'd0);
    queue_request(8'd0, 1'b1, 4'd15, {8{8'd255}}, 1'b0, 6'd0);
    // alternating bit patterns on every field
    queue_request(8'haa, 1'b0, 4'd5, {4{8'h55, 8'haa}}, 1'b0, 6'd0);
    queue_request(8'h55, 1'b1, 4'd7, {8{8'h55}}, 1'b0, 6'd0);
    // two messages over two hosts, one on each
    queue_request(8'd2, 1'b0, 4'd2, {8{8'd1}}, 1'b0, 6'd0);
    // drain everything before this one
    queue_request(8'd4, 1'b0, 4'd3, {8{8'd2}}, 1'b1, 6'd0);
    for (int idx = 0; idx < 241; idx++) request_q.insert(request_q.size(), random_request(idx));

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // wait for the last request and its results, then allow stragglers to show
    while (request_q.size() != 0 || in_valid || placement_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
